[design/palette_pixel_format_expander_top_assert.svh]
// Assertion macros for the checker file ppfe_chk.sv
`ifndef PALETTE_PIXEL_FORMAT_EXPANDER_TOP_ASSERT_SVH
`define PALETTE_PIXEL_FORMAT_EXPANDER_TOP_ASSERT_SVH

// Check on every clock edge outside reset
`define PPFE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define PPFE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ppfe_pkg.sv]
`timescale 1ns / 1ps

package ppfe_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int IDX_W       = 8;
	localparam int COLOUR_W    = 24;
	localparam int CFG_AW      = 5;
	localparam int CFG_DW      = 32;

	typedef enum logic {
		ACT_WRITE   = 1'b0,
		ACT_CONVERT = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		REG_RED_LEN   = 3'd0,
		REG_GREEN_LEN = 3'd1,
		REG_BLUE_LEN  = 3'd2,
		REG_RED_OFF   = 3'd3,
		REG_GREEN_OFF = 3'd4,
		REG_BLUE_OFF  = 3'd5,
		REG_BPP       = 3'd6,
		REG_SCALE     = 3'd7
	} reg_idx_t;

	localparam logic [3:0] RST_LEN       = 4'd8;
	localparam logic [4:0] RST_RED_OFF   = 5'd16;
	localparam logic [4:0] RST_GREEN_OFF = 5'd8;
	localparam logic [4:0] RST_BLUE_OFF  = 5'd0;
	localparam logic [2:0] RST_BPP       = 3'd4;
	localparam logic [4:0] RST_SCALE     = 5'd1;

	typedef struct packed {
		logic [3:0] red_len;
		logic [3:0] green_len;
		logic [3:0] blue_len;
		logic [4:0] red_pos;
		logic [4:0] green_pos;
		logic [4:0] blue_pos;
		logic [2:0] bpp;
		logic [4:0] scale;
	} cfg_t;

	typedef struct packed {
		logic [31:0] word;
		logic        line_end;
		logic [1:0]  nb_m1;
		logic [3:0]  cp_m1;
	} pix_t;

	function automatic logic [3:0] clamp_len(input logic [3:0] len);
		logic [3:0] n;
		if (len == 4'd0) begin
			n = 4'd1;
		end else if (len > 4'd8) begin
			n = 4'd8;
		end else begin
			n = len;
		end
		return n;
	endfunction

	function automatic logic [31:0] place_channel(input logic [7:0] v, input logic [3:0] len,
			input logic [4:0] off);
		logic [7:0] kept;
		kept = v >> (4'd8 - clamp_len(len));
		return {24'd0, kept} << off;
	endfunction

	function automatic logic [1:0] bytes_m1(input logic [2:0] bpp);
		logic [1:0] r;
		if (bpp == 3'd0) begin
			r = 2'd0;
		end else if (bpp > 3'd4) begin
			r = 2'd3;
		end else begin
			r = 2'(bpp - 3'd1);
		end
		return r;
	endfunction

	function automatic logic [3:0] copies_m1(input logic [4:0] scale);
		logic [3:0] r;
		if (scale == 5'd0) begin
			r = 4'd0;
		end else if (scale > 5'd16) begin
			r = 4'd15;
		end else begin
			r = 4'(scale - 5'd1);
		end
		return r;
	endfunction

endpackage

[design/palette_pixel_format_expander_top.sv]
// Channel   Dir  Payload
// s_*       in   tdata[7:0] index, [15:8] red, [23:16] green, [31:24] blue;
//                tuser action; tlast line end
// m_*       out  tdata byte; tuser line end; tlast final byte of pixel
// apb       in   eight registers at 4*i, writes on psel & penable & pwrite
//
// A palette write yields no output.
// A convert reads the palette RAM, then emits one byte per cycle while m_tready
// is high, bytes_per_pixel * scale bytes per pixel; the default 32-bit format gives 4.
// The next item is taken while the previous pixel's bytes drain.
// Reset clears palette valid bits at once; no clearing pass is needed.
// m_tready low holds the current byte and stalls the lookup stage.
`timescale 1ns / 1ps

module palette_pixel_format_expander_top import ppfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // color_index, red_in, green_in, blue_in
	input  logic              s_tuser,   // action
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // byte_out
	output logic              m_tuser,   // line_end_out
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;
	pix_t pix;
	logic pix_valid;
	logic pix_ready;

	ppfe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppfe_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg       (cfg),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	ppfe_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

[design/ppfe_ram.sv]
`timescale 1ns / 1ps

module ppfe_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 256
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [DATA_W-1:0]                            wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [DATA_W-1:0]                            rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/ppfe_cfg.sv]
`timescale 1ns / 1ps

module ppfe_cfg import ppfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_len   <= RST_LEN;
			cfg_q.green_len <= RST_LEN;
			cfg_q.blue_len  <= RST_LEN;
			cfg_q.red_pos   <= RST_RED_OFF;
			cfg_q.green_pos <= RST_GREEN_OFF;
			cfg_q.blue_pos  <= RST_BLUE_OFF;
			cfg_q.bpp       <= RST_BPP;
			cfg_q.scale     <= RST_SCALE;
		end else if (wr) begin
			unique case (idx)
				REG_RED_LEN:   cfg_q.red_len   <= pwdata[3:0];
				REG_GREEN_LEN: cfg_q.green_len <= pwdata[3:0];
				REG_BLUE_LEN:  cfg_q.blue_len  <= pwdata[3:0];
				REG_RED_OFF:   cfg_q.red_pos   <= pwdata[4:0];
				REG_GREEN_OFF: cfg_q.green_pos <= pwdata[4:0];
				REG_BLUE_OFF:  cfg_q.blue_pos  <= pwdata[4:0];
				REG_BPP:       cfg_q.bpp       <= pwdata[2:0];
				REG_SCALE:     cfg_q.scale     <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RED_LEN:   prdata = {28'd0, cfg_q.red_len};
			REG_GREEN_LEN: prdata = {28'd0, cfg_q.green_len};
			REG_BLUE_LEN:  prdata = {28'd0, cfg_q.blue_len};
			REG_RED_OFF:   prdata = {27'd0, cfg_q.red_pos};
			REG_GREEN_OFF: prdata = {27'd0, cfg_q.green_pos};
			REG_BLUE_OFF:  prdata = {27'd0, cfg_q.blue_pos};
			REG_BPP:       prdata = {29'd0, cfg_q.bpp};
			REG_SCALE:     prdata = {27'd0, cfg_q.scale};
		endcase
	end

endmodule

[design/ppfe_lookup.sv]
`timescale 1ns / 1ps

module ppfe_lookup import ppfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  cfg_t        cfg,
	output logic        pix_valid,
	input  logic        pix_ready,
	output pix_t        pix
);

	logic [IDX_W-1:0]       idx;
	logic [PAL_AW-1:0]      addr;
	logic [COLOUR_W-1:0]    wcolour;
	logic [COLOUR_W-1:0]    rdata;
	logic [COLOUR_W-1:0]    colour;
	logic                   in_range;
	logic                   accept;
	logic                   wr;
	logic                   rd;
	logic [PAL_ENTRIES-1:0] valid_q;
	logic                   valid_s1;
	logic                   hit_s1;
	logic                   le_s1;

	assign idx      = s_tdata[7:0];
	assign addr     = idx[PAL_AW-1:0];
	assign wcolour  = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
	assign in_range = {1'b0, idx} < (IDX_W + 1)'(PAL_ENTRIES);
	assign s_tready = !valid_s1 || pix_ready;
	assign accept   = s_tvalid && s_tready;
	assign wr       = accept && (action_t'(s_tuser) == ACT_WRITE) && in_range;
	assign rd       = accept && (action_t'(s_tuser) == ACT_CONVERT);

	ppfe_ram #(
		.DATA_W (COLOUR_W),
		.DEPTH  (PAL_ENTRIES)
	) u_pal (
		.clk   (clk),
		.we    (wr),
		.waddr (addr),
		.wdata (wcolour),
		.re    (rd),
		.raddr (addr),
		.rdata (rdata)
	);

	// entries never written read as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr) begin
			valid_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd) begin
			valid_s1 <= 1'b1;
		end else if (pix_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			hit_s1 <= in_range && valid_q[addr];
			le_s1  <= s_tlast;
		end
	end

	assign colour    = hit_s1 ? rdata : '0;
	assign pix_valid = valid_s1;

	always_comb begin
		pix.word     = place_channel(colour[23:16], cfg.red_len, cfg.red_pos)
		             | place_channel(colour[15:8], cfg.green_len, cfg.green_pos)
		             | place_channel(colour[7:0], cfg.blue_len, cfg.blue_pos);
		pix.line_end = le_s1;
		pix.nb_m1    = bytes_m1(cfg.bpp);
		pix.cp_m1    = copies_m1(cfg.scale);
	end

endmodule

[design/ppfe_emit.sv]
`timescale 1ns / 1ps

module ppfe_emit import ppfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  pix_t       pix,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tuser,
	output logic       m_tlast
);

	logic        valid_s2;
	pix_t        pix_s2;
	logic [1:0]  byte_q;
	logic [3:0]  copy_q;
	logic        final_byte;
	logic        done;
	logic        load;
	logic [31:0] shifted;

	assign final_byte = (byte_q == pix_s2.nb_m1) && (copy_q == pix_s2.cp_m1);
	assign done       = valid_s2 && m_tready && final_byte;
	assign pix_ready  = !valid_s2 || done;
	assign load       = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			byte_q   <= '0;
			copy_q   <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			byte_q   <= '0;
			copy_q   <= '0;
		end else if (done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && m_tready) begin
			// advance byte, wrap into next copy
			if (byte_q == pix_s2.nb_m1) begin
				byte_q <= '0;
				copy_q <= copy_q + 4'd1;
			end else begin
				byte_q <= byte_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_s2 <= pix;
		end
	end

	assign shifted  = pix_s2.word >> {byte_q, 3'b000};
	assign m_tvalid = valid_s2;
	assign m_tdata  = shifted[7:0];
	assign m_tlast  = final_byte;
	assign m_tuser  = final_byte && pix_s2.line_end;

endmodule

[design/ppfe_chk.sv]
`timescale 1ns / 1ps
`include "palette_pixel_format_expander_top_assert.svh"

module ppfe_chk import ppfe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	logic       m_stall;
	logic [9:0] m_beat;
	logic       s_conv;

	assign m_stall = m_tvalid && !m_tready;
	assign m_beat  = {m_tdata, m_tlast, m_tuser};
	assign s_conv  = s_tvalid && s_tready && (action_t'(s_tuser) == ACT_CONVERT);

	`PPFE_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !m_tvalid, "output valid during reset")

	`PPFE_ASSERT(a_hold, m_stall |=> m_tvalid && $stable(m_beat), "held transaction changed")

	`PPFE_ASSERT(a_line_end_on_last, m_tvalid && m_tuser |-> m_tlast, "line end away from final byte")

	`PPFE_ASSERT(a_ready_when_drained, !m_tvalid |-> s_tready, "input blocked with output drained")

	`PPFE_ASSERT(a_convert_emits, s_conv && !m_tvalid |-> ##2 m_tvalid, "convert produced no byte")

endmodule

bind palette_pixel_format_expander_top ppfe_chk u_ppfe_chk (.*);

[sim/ppfe_output_checker.sv]
`timescale 1ns / 1ps

module ppfe_output_checker import ppfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [31:0]       s_tdata,   // color_index, red_in, green_in, blue_in
	input  logic              s_tuser,   // action
	input  logic              s_tlast,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,   // byte_out
	input  logic              m_tuser,   // line_end_out
	input  logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output int                mismatches,
	output int                outstanding
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       line_end;
	} fb_byte_t;

	cfg_t                fmt;
	logic [COLOUR_W-1:0] palette_ram [PAL_ENTRIES];
	fb_byte_t            pending_bytes [$];

	function automatic logic [31:0] place_bits(input logic [7:0] v, input logic [3:0] len,
			input logic [4:0] off);
		int keep;
		logic [31:0] w;
		keep = (len == 4'd0) ? 1 : ((len > 4'd8) ? 8 : int'(len));
		w = {24'd0, v} >> (8 - keep);
		return w << off;
	endfunction

	function automatic logic [31:0] pack_word(input logic [COLOUR_W-1:0] rgb);
		return place_bits(rgb[23:16], fmt.red_len, fmt.red_pos) |
			place_bits(rgb[15:8], fmt.green_len, fmt.green_pos) |
			place_bits(rgb[7:0], fmt.blue_len, fmt.blue_pos);
	endfunction

	function automatic void queue_pixel(input logic [COLOUR_W-1:0] rgb, input logic line_end);
		logic [31:0] word;
		int nbytes;
		int copies;
		fb_byte_t b;
		word = pack_word(rgb);
		nbytes = (fmt.bpp == 3'd0) ? 1 : ((fmt.bpp > 3'd4) ? 4 : int'(fmt.bpp));
		copies = (fmt.scale == 5'd0) ? 1 : ((fmt.scale > 5'd16) ? 16 : int'(fmt.scale));
		for (int k = 0; k < copies; k++) begin
			for (int j = 0; j < nbytes; j++) begin
				b.data = word[8*j +: 8];
				b.last = (k == copies - 1) && (j == nbytes - 1);
				b.line_end = b.last & line_end;
				pending_bytes.push_back(b);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		fb_byte_t want;
		int bad;
		if (!arst_n) begin
			fmt <= '{red_len: RST_LEN, green_len: RST_LEN, blue_len: RST_LEN,
				red_pos: RST_RED_OFF, green_pos: RST_GREEN_OFF, blue_pos: RST_BLUE_OFF,
				bpp: RST_BPP, scale: RST_SCALE};
			for (int i = 0; i < PAL_ENTRIES; i++) begin
				palette_ram[i] <= '0;
			end
			pending_bytes.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (m_tvalid && m_tready) begin
				if (pending_bytes.size() == 0) begin
					$error("byte_out %0h arrived with no pixel byte outstanding", m_tdata);
					bad++;
				end else begin
					want = pending_bytes.pop_front();
					if (m_tdata !== want.data) begin
						$error("byte_out expected %0h actual %0h", want.data, m_tdata);
						bad++;
					end
					if (m_tlast !== want.last) begin
						$error("last expected %0b actual %0b", want.last, m_tlast);
						bad++;
					end
					if (m_tuser !== want.line_end) begin
						$error("line_end_out expected %0b actual %0b", want.line_end, m_tuser);
						bad++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (action_t'(s_tuser) == ACT_WRITE) begin
					palette_ram[s_tdata[7:0]] <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
				end else begin
					queue_pixel(palette_ram[s_tdata[7:0]], s_tlast);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[CFG_AW-1:2]))
					REG_RED_LEN:   fmt.red_len   <= pwdata[3:0];
					REG_GREEN_LEN: fmt.green_len <= pwdata[3:0];
					REG_BLUE_LEN:  fmt.blue_len  <= pwdata[3:0];
					REG_RED_OFF:   fmt.red_pos   <= pwdata[4:0];
					REG_GREEN_OFF: fmt.green_pos <= pwdata[4:0];
					REG_BLUE_OFF:  fmt.blue_pos  <= pwdata[4:0];
					REG_BPP:       fmt.bpp       <= pwdata[2:0];
					REG_SCALE:     fmt.scale     <= pwdata[4:0];
					default: ;
				endcase
			end
			mismatches <= mismatches + bad;
			outstanding <= pending_bytes.size();
		end
	end

endmodule

[sim/palette_pixel_format_expander_top_tb.sv]
`timescale 1ns / 1ps

module palette_pixel_format_expander_top_tb;
	import ppfe_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 150;
	localparam int PHASE_ITEMS = 21;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;   // color_index, red_in, green_in, blue_in
	logic              s_tuser;   // action
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;   // byte_out
	logic              m_tuser;   // line_end_out
	logic              m_tlast;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	int         mismatches;
	int         outstanding;
	int         quiet_cycles = 0;
	bit         tx_burst;
	bit         rx_burst;
	bit         hold_request;
	logic [7:0] loaded_idx [$];

	always #6 clk = ~clk;

	palette_pixel_format_expander_top dut (.*);

	ppfe_output_checker check_out (.*);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("palette_pixel_format_expander_top verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : rx_side
		int gap;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		m_tready <= 1'b1;
		forever begin
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(29) == 0) begin
				rx_burst = !rx_burst;
			end
			gap = rx_burst ? 0 : $urandom_range(5);
			if (hold_request) begin
				hold_request = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	task automatic offer(input action_t act, input logic [7:0] idx, input logic [23:0] rgb,
			input logic line_end);
		int gap;
		if ($urandom_range(14) == 0) begin
			tx_burst = !tx_burst;
		end
		gap = tx_burst ? 0 : $urandom_range(5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tlast <= line_end;
		s_tdata <= {rgb[7:0], rgb[15:8], rgb[23:16], idx};
		do @(posedge clk); while (!s_tready);
		if (act == ACT_WRITE) begin
			loaded_idx.push_back(idx);
		end
	endtask

	task automatic drain_output();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic settle();
		drain_output();
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t r, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'({r, 2'b00});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_format(input int rl, input int gl, input int bl, input int ro,
			input int go, input int bo, input int bpp, input int sc);
		apb_write(REG_RED_LEN, 32'(rl));
		apb_write(REG_GREEN_LEN, 32'(gl));
		apb_write(REG_BLUE_LEN, 32'(bl));
		apb_write(REG_RED_OFF, 32'(ro));
		apb_write(REG_GREEN_OFF, 32'(go));
		apb_write(REG_BLUE_OFF, 32'(bo));
		apb_write(REG_BPP, 32'(bpp));
		apb_write(REG_SCALE, 32'(sc));
	endtask

	task automatic random_item();
		logic [7:0] idx;
		if (loaded_idx.size() == 0 || $urandom_range(9) < 4) begin
			offer(ACT_WRITE, 8'($urandom), 24'($urandom), 1'($urandom));
		end else begin
			idx = ($urandom_range(9) < 8) ?
				loaded_idx[$urandom_range(loaded_idx.size() - 1)] : 8'($urandom);
			offer(ACT_CONVERT, idx, 24'($urandom), 1'($urandom));
		end
	endtask

	initial begin : stimulus
		int sc;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		hold_request = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(ACT_CONVERT, 8'd7, 24'h000000, 1'b0);
		offer(ACT_WRITE, 8'd0, 24'h000000, 1'b0);
		offer(ACT_WRITE, 8'd255, 24'hffffff, 1'b1);
		offer(ACT_WRITE, 8'h80, 24'ha55a3c, 1'b0);
		offer(ACT_WRITE, 8'h01, 24'h0180fe, 1'b1);
		offer(ACT_CONVERT, 8'd255, 24'h000000, 1'b1);
		offer(ACT_CONVERT, 8'd0, 24'hffffff, 1'b0);
		offer(ACT_CONVERT, 8'h80, 24'h000000, 1'b1);
		offer(ACT_CONVERT, 8'h01, 24'h000000, 1'b0);
		offer(ACT_WRITE, 8'd255, 24'h123456, 1'b0);
		offer(ACT_CONVERT, 8'd255, 24'h000000, 1'b1);
		offer(ACT_WRITE, 8'h7f, 24'h7fff00, 1'b0);
		offer(ACT_CONVERT, 8'h7f, 24'h000000, 1'b0);

		settle();
		load_format(1, 1, 1, 31, 31, 31, 1, 16);
		offer(ACT_CONVERT, 8'd255, 24'h000000, 1'b1);
		offer(ACT_CONVERT, 8'h80, 24'h000000, 1'b0);

		settle();
		load_format(0, 15, 8, 0, 30, 25, 0, 0);
		offer(ACT_CONVERT, 8'h80, 24'h000000, 1'b1);
		offer(ACT_CONVERT, 8'd255, 24'h000000, 1'b0);
		offer(ACT_CONVERT, 8'h01, 24'h000000, 1'b1);

		settle();
		load_format(8, 9, 0, 29, 24, 28, 7, 31);
		offer(ACT_CONVERT, 8'h80, 24'h000000, 1'b1);

		for (int p = 0; p < 8; p++) begin
			settle();
			if (p == 0) begin
				load_format(8, 8, 8, 16, 8, 0, 4, 1);
				hold_request = 1'b1;
			end else begin
				sc = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 3);
				load_format($urandom_range(15), $urandom_range(15), $urandom_range(15),
					$urandom_range(31), $urandom_range(31), $urandom_range(31),
					$urandom_range(7), sc);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((p == 1 && n == 10) || $urandom_range(24) == 0) begin
					drain_output();
				end
				random_item();
			end
		end

		drain_output();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("palette_pixel_format_expander_top verification clean");
		end else begin
			$display("palette_pixel_format_expander_top verification failed");
		end
		$finish;
	end

endmodule
